// ===== rtl/rrts_pkg.sv =====
`default_nettype none
package rrts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int ID_W      = 4;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] task_id;
    logic            still_runnable;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] running_task;
    logic            running_valid;
    logic            switched;
    logic [ID_W-1:0] previous_task;
    logic            previous_valid;
    logic            overflow;
  } out_t;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] push_id;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/rrts_cell.sv =====
`default_nettype none
module rrts_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rrts_pkg::cell_ctl_t     ctl,
  input  logic                    left_occ,
  input  logic                    right_occ,
  input  logic [rrts_pkg::ID_W-1:0] right_id,
  output logic                    occ,
  output logic [rrts_pkg::ID_W-1:0] id
);
  import rrts_pkg::*;

  logic            occ_r, occ_nxt;
  logic [ID_W-1:0] id_r, id_nxt;

  always_comb begin
    occ_nxt = occ_r;
    id_nxt  = id_r;
    priority if (ctl.pop && ctl.push) begin
      if (occ_r && !right_occ) begin
        id_nxt = ctl.push_id;
      end else if (occ_r) begin
        id_nxt = right_id;
      end
    end else if (ctl.pop) begin
      occ_nxt = right_occ;
      id_nxt  = right_id;
    end else if (ctl.push) begin
      if (!occ_r && left_occ) begin
        occ_nxt = 1'b1;
        id_nxt  = ctl.push_id;
      end
    end else begin
      occ_nxt = occ_r;
      id_nxt  = id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign occ = occ_r;
  assign id  = id_r;

endmodule
`default_nettype wire

// ===== rtl/rrts_queue.sv =====
`default_nettype none
module rrts_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rrts_pkg::cell_ctl_t       ctl,
  output logic [rrts_pkg::ID_W-1:0] head_id,
  output logic                      empty,
  output logic                      full
);
  import rrts_pkg::*;

  logic            occ_w [MAX_TASKS];
  logic [ID_W-1:0] id_w  [MAX_TASKS];

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic            left_occ;
    logic            right_occ;
    logic [ID_W-1:0] right_id;

    if (i == 0) begin : g_first
      assign left_occ = 1'b1;
    end else begin : g_mid_l
      assign left_occ = occ_w[i-1];
    end

    if (i == MAX_TASKS-1) begin : g_last
      assign right_occ = 1'b0;
      assign right_id  = '0;
    end else begin : g_mid_r
      assign right_occ = occ_w[i+1];
      assign right_id  = id_w[i+1];
    end

    rrts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_occ  (left_occ),
      .right_occ (right_occ),
      .right_id  (right_id),
      .occ       (occ_w[i]),
      .id        (id_w[i])
    );
  end

  assign head_id = id_w[0];
  assign empty   = !occ_w[0];
  assign full    = occ_w[MAX_TASKS-1];

  // Occupancy must stay a contiguous run starting at the head cell.
  assert property (@(posedge clk) disable iff (!rst_n) full |-> !empty)
    else $error("queue full while head cell is empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.pop && !ctl.push) |=> !full)
    else $error("queue still full after a pop without push");

endmodule
`default_nettype wire

// ===== rtl/round_robin_task_scheduler_top.sv =====
// Channel  Handshake                  Payload
// input    start, busy                in_data  (rrts_pkg::in_t)
// result   out_strobe                 out_data (rrts_pkg::out_t)
//
// A beat is accepted on a rising edge with start high and busy low; busy stays low.
// Each accepted beat yields one result beat in the following cycle, so one item per cycle.
// The ready queue is a row of cells that shift toward the head on every pop.
// Reset is synchronous and active low; the queue comes up empty with no task running.
// The receiver cannot stall; out_strobe is high for exactly one cycle per result.
`default_nettype none
module round_robin_task_scheduler_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rrts_pkg::in_t  in_data,
  output logic           out_strobe,
  output rrts_pkg::out_t out_data
);
  import rrts_pkg::*;

  logic            accept;
  logic            is_tick;
  logic            do_switch;
  logic [ID_W-1:0] head_id;
  logic            empty;
  logic            full;
  cell_ctl_t       ctl;

  logic            cur_valid_r, cur_valid_nxt;
  logic [ID_W-1:0] cur_id_r, cur_id_nxt;
  logic            strobe_r;
  out_t            res_r, res_nxt;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_tick   = (in_data.mode == MODE_TICK);
  assign do_switch = accept && is_tick && !empty;

  always_comb begin
    ctl.pop     = do_switch;
    ctl.push    = accept && ((!is_tick && !full) ||
                             (do_switch && cur_valid_r && in_data.still_runnable));
    ctl.push_id = is_tick ? cur_id_r : in_data.task_id;
  end

  rrts_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .head_id (head_id),
    .empty   (empty),
    .full    (full)
  );

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_id_nxt    = cur_id_r;
    if (do_switch) begin
      cur_valid_nxt = 1'b1;
      cur_id_nxt    = head_id;
    end
    res_nxt.running_task   = cur_valid_nxt ? cur_id_nxt : '0;
    res_nxt.running_valid  = cur_valid_nxt;
    res_nxt.switched       = do_switch;
    res_nxt.previous_valid = do_switch && cur_valid_r;
    res_nxt.previous_task  = (do_switch && cur_valid_r) ? cur_id_r : '0;
    res_nxt.overflow       = accept && !is_tick && full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_id_r    <= '0;
      strobe_r    <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cur_id_r    <= cur_id_nxt;
      strobe_r    <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = res_r;

  assert property (@(posedge clk) disable iff (!rst_n) accept |=> out_strobe)
    else $error("accepted beat produced no result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.switched |-> out_data.running_valid)
    else $error("switch reported with no running task");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.overflow |-> !out_data.switched && !out_data.previous_valid)
    else $error("overflow reported on a tick");

  assert property (@(posedge clk) disable iff (!rst_n)
    do_switch && cur_valid_r && !in_data.still_runnable |=> !full)
    else $error("blocked task switch left the queue full");

endmodule
`default_nettype wire
